FILE: hdl/tbl_pkg.sv
package tbl_pkg;

  // command codes
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_CONSUME = 3'd1;
  localparam logic [2:0] CMD_RESTORE = 3'd2;
  localparam logic [2:0] CMD_RESET   = 3'd3;
  localparam logic [2:0] CMD_TEST    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_START_COUNT = 2'd0;
  localparam logic [1:0] REG_MAX_TOKENS  = 2'd1;
  localparam logic [1:0] REG_REFILL_RATE = 2'd2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] amount;
    logic [15:0] elapsed_ticks;
  } req_t;

  typedef struct packed {
    logic        granted;
    logic        exhausted;
    logic [31:0] balance;
    logic [47:0] total_consumed;
  } rsp_t;

endpackage

FILE: hdl/token_bucket_limiter_top.sv
// token bucket rate limiter, unsigned Q16.16 balances
//
// channels: req (cmd, amount, elapsed_ticks) in, rsp (granted, exhausted,
// balance, total_consumed) out, both valid/ready; a transfer happens on a
// rising edge with valid and ready high. cfg is a write-only valid/ready
// channel (index 0 start_count, 1 max_tokens, 2 refill_rate); cfg_ready is
// always high and index 3 is dropped. write cfg only while the block is idle.
//
// a req transfer loads the input register, and the result is then registered
// in the result register, from which it can transfer. throughput is one item
// per cycle while the receiver does not stall: the tick refill product is formed
// on the way into the input register, and the balance/total update (one add,
// compare and select) runs from it into the state and result registers.
//
// reset (rst, synchronous): config returns to start_count 0, max_tokens all
// ones, refill_rate 0; balance and total clear; both stages empty.
// when the receiver stalls, the result register holds, the input register
// keeps one more item, and req_ready drops once both are full.
module token_bucket_limiter_top
  import tbl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  // result channel
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  // configuration registers
  logic [31:0] start_count;
  logic [31:0] max_tokens;
  logic [31:0] refill_rate;

  // bucket state
  logic [31:0] token_balance;
  logic [31:0] token_balance_next;
  logic [47:0] consumed_total;
  logic [47:0] consumed_total_next;

  // input register
  logic        s1_valid;
  logic [2:0]  s1_cmd;
  logic [31:0] s1_amount;
  logic [47:0] s1_refill;
  logic        s1_ticks_nz;

  // handshake control
  logic s1_move;
  logic req_xfer;

  // datapath
  logic [47:0] refill_prod;
  logic [47:0] add_in;
  logic [48:0] add_sum;
  logic [31:0] add_clamped;
  logic        enough;
  logic [31:0] take;
  logic [48:0] total_sum;
  logic [47:0] total_sat;
  logic        granted_next;
  logic        exhausted_next;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  // input register advances when the result register is free or draining
  assign s1_move   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || s1_move;
  assign req_xfer  = req_valid && req_ready;

  // refill product: 16 bit ticks times 32 bit Q16.16 rate, exact in 48 bits
  assign refill_prod = 48'(req.elapsed_ticks) * 48'(refill_rate);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_count <= '0;
      max_tokens  <= '1;
      refill_rate <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START_COUNT: start_count <= cfg_wdata;
        REG_MAX_TOKENS:  max_tokens  <= cfg_wdata;
        REG_REFILL_RATE: refill_rate <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      s1_cmd      <= req.cmd;
      s1_amount   <= req.amount;
      s1_refill   <= refill_prod;
      s1_ticks_nz <= (req.elapsed_ticks != '0);
    end
  end

  // shared saturating add for tick and restore
  assign add_in      = (s1_cmd == CMD_TICK) ? s1_refill : {16'b0, s1_amount};
  assign add_sum     = 49'(token_balance) + 49'(add_in);
  assign add_clamped = (add_sum > 49'(max_tokens)) ? max_tokens : add_sum[31:0];

  // consume: full grant or drain whatever is left
  assign enough    = (token_balance >= s1_amount);
  assign take      = enough ? s1_amount : token_balance;
  assign total_sum = 49'(consumed_total) + 49'(take);
  assign total_sat = total_sum[48] ? '1 : total_sum[47:0];

  always_comb begin
    token_balance_next  = token_balance;
    consumed_total_next = consumed_total;
    granted_next        = 1'b0;
    exhausted_next      = 1'b0;
    unique case (s1_cmd)
      CMD_TICK: begin
        // zero ticks leaves the balance alone, even above capacity
        if (s1_ticks_nz) begin
          token_balance_next = add_clamped;
        end
      end
      CMD_CONSUME: begin
        consumed_total_next = total_sat;
        if (enough) begin
          token_balance_next = token_balance - s1_amount;
          granted_next       = 1'b1;
        end else begin
          token_balance_next = '0;
          exhausted_next     = 1'b1;
        end
      end
      CMD_RESTORE: token_balance_next = add_clamped;
      CMD_RESET:   token_balance_next = start_count;
      CMD_TEST:    granted_next = enough;
      default: ;
    endcase
  end

  // bucket state
  always_ff @(posedge clk) begin
    if (rst) begin
      token_balance  <= '0;
      consumed_total <= '0;
    end else if (s1_move) begin
      token_balance  <= token_balance_next;
      consumed_total <= consumed_total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_move) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rsp.granted        <= granted_next;
      rsp.exhausted      <= exhausted_next;
      rsp.balance        <= token_balance_next;
      rsp.total_consumed <= consumed_total_next;
    end
  end

  // a result is never both a grant and an exhaustion
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.granted && rsp.exhausted))
    else $error("granted and exhausted both set");

  // exhaustion always leaves an empty bucket
  a_exhaust_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.exhausted |-> rsp.balance == '0)
    else $error("exhausted with nonzero balance");

  // running total never goes down
  a_total_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> consumed_total >= $past(consumed_total))
    else $error("consumed total decreased");

  // a stalled result keeps the queued item in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && rsp_valid && !rsp_ready |=> s1_valid)
    else $error("input register lost an item under stall");

endmodule

FILE: tb/tb_token_bucket_limiter_top.sv
module tb_token_bucket_limiter_top
  import tbl_pkg::*;
();

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [47:0] TOTAL_CEIL = 48'hFFFF_FFFF_FFFF;
  localparam int WATCHDOG_LIMIT = 5000;  // quiet cycles before the run is abandoned
  localparam int TAIL_CYCLES = 20;
  localparam int HOLD_CYCLES = 400;      // long receiver hold-off, fills both stages
  localparam int PHASE_ITEMS = 240;
  localparam int NUM_PHASES = 6;

  // bucket predictor plus queue of expected results
  class bucket_scoreboard;
    rsp_t pending_rsp[$];
    logic [31:0] start_cnt;
    logic [31:0] cap;
    logic [31:0] rate;
    logic [31:0] bal;
    logic [47:0] used;
    int errors;

    function new();
      start_cnt = '0;
      cap = ALL_ONES;
      rate = '0;
      bal = '0;
      used = '0;
      errors = 0;
    endfunction

    function int pending();
      return pending_rsp.size();
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_START_COUNT: start_cnt = data;
        REG_MAX_TOKENS:  cap = data;
        REG_REFILL_RATE: rate = data;
        default: ;
      endcase
    endfunction

    // saturating add into the running total
    function void add_used(logic [31:0] v);
      logic [48:0] s;
      s = {1'b0, used} + {17'b0, v};
      used = (s > {1'b0, TOTAL_CEIL}) ? TOTAL_CEIL : s[47:0];
    endfunction

    // add to the balance, clamp at capacity (also clamps an over-full balance)
    function void add_clamped(logic [47:0] v);
      logic [48:0] s;
      s = {17'b0, bal} + {1'b0, v};
      bal = (s > {17'b0, cap}) ? cap : s[31:0];
    endfunction

    function void note_req(req_t r);
      rsp_t want;
      want = '0;
      case (r.cmd)
        CMD_TICK: begin
          if (r.elapsed_ticks != 0)
            add_clamped({32'b0, r.elapsed_ticks} * {16'b0, rate});
        end
        CMD_CONSUME: begin
          if (bal >= r.amount) begin
            bal = bal - r.amount;
            add_used(r.amount);
            want.granted = 1'b1;
          end else begin
            // drain whatever is left
            add_used(bal);
            bal = '0;
            want.exhausted = 1'b1;
          end
        end
        CMD_RESTORE: add_clamped({16'b0, r.amount});
        CMD_RESET:   bal = start_cnt;
        CMD_TEST:    want.granted = (bal >= r.amount);
        default: ;
      endcase
      want.balance = bal;
      want.total_consumed = used;
      pending_rsp.push_back(want);
    endfunction

    task report(string msg);
      if (errors < 100)
        $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_rsp(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        report("result transfer with nothing expected");
        return;
      end
      want = pending_rsp.pop_front();
      if (got.granted !== want.granted)
        report($sformatf("granted %b, want %b", got.granted, want.granted));
      if (got.exhausted !== want.exhausted)
        report($sformatf("exhausted %b, want %b", got.exhausted, want.exhausted));
      if (got.balance !== want.balance)
        report($sformatf("balance %h, want %h", got.balance, want.balance));
      if (got.total_consumed !== want.total_consumed)
        report($sformatf("total_consumed %h, want %h", got.total_consumed,
                         want.total_consumed));
    endtask
  endclass

  // dut signals, all inputs known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  bucket_scoreboard sb = new();

  // idling percentages for the current phase
  int send_idle = 0;
  int recv_stall = 0;
  // bumped by the main flow to ask the receiver for a long hold-off
  int hold_trig = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet = 0;

  token_bucket_limiter_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitor: sample handshakes on the edge, before any update lands
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready)
        sb.write_reg(cfg_index, cfg_wdata);
      if (req_valid && req_ready)
        sb.note_req(req);
      if (rsp_valid && rsp_ready)
        sb.check_rsp(rsp);
    end
  end

  // receiver: random stalls, or a counted hold-off when asked
  always @(posedge clk) begin
    if (hold_trig != hold_seen) begin
      hold_seen = hold_trig;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // watchdog: abandon the run after a long stretch with no transfer at all
  initial begin
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // offer one request, with a random idle gap first; returns at its transfer edge
  task send_item(req_t r);
    if ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // sender pauses until every expected result has come back
  task wait_drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_index <= idx;
    cfg_wdata <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task load_cfg(logic [31:0] start, logic [31:0] cap, logic [31:0] rate);
    write_reg(REG_START_COUNT, start);
    write_reg(REG_MAX_TOKENS, cap);
    write_reg(REG_REFILL_RATE, rate);
  endtask

  // random request, amounts often near the predicted balance to hit the compare edge
  function automatic req_t pick_req();
    req_t r;
    int sel;
    sel = $urandom_range(99);
    if (sel < 20)      r.cmd = CMD_TICK;
    else if (sel < 45) r.cmd = CMD_CONSUME;
    else if (sel < 65) r.cmd = CMD_RESTORE;
    else if (sel < 72) r.cmd = CMD_RESET;
    else if (sel < 94) r.cmd = CMD_TEST;
    else               r.cmd = CMD_TEST + 3'($urandom_range(3, 1));  // unused codes
    sel = $urandom_range(99);
    if (sel < 10)      r.amount = '0;
    else if (sel < 20) r.amount = ALL_ONES;
    else if (sel < 45) r.amount = sb.bal + 32'($urandom_range(4)) - 32'd2;
    else if (sel < 70) r.amount = 32'($urandom_range(32'h000F_FFFF));
    else               r.amount = $urandom();
    sel = $urandom_range(99);
    if (sel < 15)      r.elapsed_ticks = '0;
    else if (sel < 25) r.elapsed_ticks = 16'hFFFF;
    else if (sel < 65) r.elapsed_ticks = 16'($urandom_range(16, 1));
    else               r.elapsed_ticks = 16'($urandom());
    return r;
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed, reset defaults: start 0, capacity all ones, rate 0
    send_item('{CMD_TICK, 32'd0, 16'd0});             // zero ticks do nothing
    send_item('{CMD_TICK, 32'd0, 16'hFFFF});          // zero rate
    send_item('{CMD_CONSUME, 32'd0, 16'd0});          // empty bucket covers zero
    send_item('{CMD_CONSUME, 32'd1, 16'd0});          // exhaustion on empty bucket
    send_item('{CMD_RESTORE, ALL_ONES, 16'd0});
    send_item('{CMD_RESTORE, 32'd1, 16'd0});          // saturates at capacity
    send_item('{CMD_TEST, ALL_ONES, 16'd0});
    send_item('{CMD_CONSUME, 32'h0001_0000, 16'd0});
    send_item('{CMD_TEST, ALL_ONES, 16'd0});          // now short by one token
    send_item('{CMD_CONSUME, ALL_ONES, 16'd0});       // drains the rest
    send_item('{CMD_TEST + 3'd1, ALL_ONES, 16'hFFFF}); // unused codes
    send_item('{CMD_TEST + 3'd2, 32'd0, 16'd0});
    send_item('{CMD_TEST + 3'd3, ALL_ONES, 16'hFFFF});
    send_item('{CMD_RESET, 32'd0, 16'd0});

    // start count above capacity
    wait_drain();
    load_cfg(ALL_ONES, 32'h0010_0000, 32'h0001_8000);
    send_item('{CMD_RESET, 32'd0, 16'd0});            // balance over capacity
    send_item('{CMD_TEST, ALL_ONES, 16'd0});          // test does not clamp
    send_item('{CMD_CONSUME, 32'd1, 16'd0});          // consume does not clamp
    send_item('{CMD_TICK, 32'd0, 16'd0});             // zero ticks do not clamp
    send_item('{CMD_RESTORE, 32'd0, 16'd0});          // restore of zero clamps
    send_item('{CMD_RESET, 32'd0, 16'd0});
    send_item('{CMD_TICK, 32'd0, 16'd1});             // tick clamps
    send_item('{CMD_CONSUME, 32'h0000_8000, 16'd0});
    send_item('{CMD_TICK, 32'd0, 16'd3});             // refill past capacity clamps
    wait_drain();
    write_reg(REG_REFILL_RATE, ALL_ONES);
    send_item('{CMD_CONSUME, 32'h0008_0000, 16'd0});
    send_item('{CMD_TICK, 32'd0, 16'hFFFF});          // widest refill product
    wait_drain();
    write_reg(REG_REFILL_RATE, 32'd0);
    send_item('{CMD_RESET, 32'd0, 16'd0});
    send_item('{CMD_TICK, 32'd0, 16'd1});             // clamps with zero rate

    // random phases, each with its own idling and configuration
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drain();
      case (p)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 82; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 82; end
        3: begin send_idle = 25; recv_stall = 25; end
        4: begin send_idle = 0;  recv_stall = 0;  end
        default: begin send_idle = 25; recv_stall = 25; end
      endcase
      case (p)
        0: load_cfg(32'h0008_0000, 32'h0040_0000, 32'h0001_0000);
        1: load_cfg(ALL_ONES, ALL_ONES, ALL_ONES);
        2: load_cfg(32'd0, 32'd0, 32'd0);
        default: load_cfg(($urandom_range(1) != 0) ? $urandom()
                                                   : 32'($urandom_range(64)) << 16,
                          ($urandom_range(3) == 0) ? ALL_ONES
                            : 32'($urandom_range(32'h0100_0000, 32'h0001_0000)),
                          ($urandom_range(3) == 0) ? $urandom()
                            : 32'($urandom_range(32'h0002_0000)));
      endcase
      // receiver holds off while the sender keeps offering, so req_ready drops
      if (p == 4)
        hold_trig++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_item(pick_req());
        if ($urandom_range(99) == 0)
          wait_drain();
      end
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
